### hw/rtl/lkfs_pkg.sv
// Shared types, constants and a helper function of the Lucas-Kanade flow solver.
`default_nettype none
package lkfs_pkg;

  localparam int IMG_W = 64;
  localparam int IMG_H = 64;
  localparam int WIN_R = 2;

  localparam int PIX_XW = 6;
  localparam int PIX_YW = 6;
  localparam int VAL_W = 8;
  localparam int FLOW_W = 32;

  localparam int ADDR_W = $clog2(IMG_W * IMG_H);
  localparam int DIM_W = $clog2((IMG_W > IMG_H) ? IMG_W : IMG_H);
  localparam int C_W = ((DIM_W > PIX_XW) ? DIM_W : PIX_XW) + 2;

  localparam int TAPS = (2 * WIN_R + 1) * (2 * WIN_R + 1);
  localparam int PROD_W = 2 * VAL_W + 1;
  localparam int SUM_W = PROD_W + $clog2(TAPS) + 1;
  localparam int MUL_W = 2 * SUM_W;
  localparam int NUM_W = MUL_W + 1;
  localparam int FRAC_W = 16;
  localparam int DIVD_W = NUM_W + FRAC_W;

  localparam int Q_DEPTH = 2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic signed [C_W-1:0] COL_MAX = C_W'(IMG_W - 1);
  localparam logic signed [C_W-1:0] ROW_MAX = C_W'(IMG_H - 1);

  typedef struct packed {
    logic              kind;
    logic [PIX_XW-1:0] pixel_x;
    logic [PIX_YW-1:0] pixel_y;
    logic [VAL_W-1:0]  first_value;
    logic [VAL_W-1:0]  second_value;
  } in_item_t;

  typedef struct packed {
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic                     solved;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FLOW_W-1:0] quot;
  } div_rsp_t;

  // Clamps a window coordinate pair to the image and forms the linear address.
  function automatic logic [ADDR_W-1:0] pix_addr(input logic signed [C_W-1:0] col,
                                                 input logic signed [C_W-1:0] row);
    logic signed [C_W-1:0] c;
    logic signed [C_W-1:0] r;
    c = col;
    r = row;
    if (col < 0) begin
      c = '0;
    end else if (col > COL_MAX) begin
      c = COL_MAX;
    end
    if (row < 0) begin
      r = '0;
    end else if (row > ROW_MAX) begin
      r = ROW_MAX;
    end
    return ADDR_W'(unsigned'(r)) * ADDR_W'(IMG_W) + ADDR_W'(unsigned'(c));
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lucas_kanade_flow_solver_unit.sv
// Top level of the Lucas-Kanade flow solver: front queue, back end and checks.
//
//   channel | direction | handshake                | payload
//   input   | in        | in_valid_i / in_ready_o  | in_data_i  (in_item_t)
//   output  | out       | out_valid_o / out_ready_i| out_data_o (out_item_t)
//
// A load is written into both image stores as it leaves the two-entry queue.
// A query walks the (2R+1)^2 window, each tap stepping through seven phases on the single
// read port of the first-image store, then runs the shared multiplier sequence and,
// when the determinant exceeds one, two passes of the bit-serial divider. The queue keeps
// taking items while it has room and the back end works; a held result stalls only the
// next query. Reset is asynchronous and active low; the image stores are not cleared.
`default_nettype none
module lucas_kanade_flow_solver_unit import lkfs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  logic     q_valid, q_ready;
  in_item_t q_item;

  lkfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  lkfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_unsolved_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.solved |-> out_data_o.flow_x == '0 && out_data_o.flow_y == '0)
    else $error("unsolved result carries nonzero flow");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue reports full while empty");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready && q_item.kind == KIND_QUERY |=> !q_ready)
    else $error("back end took another transaction right after a query");
`endif

endmodule
`default_nettype wire

### hw/rtl/lkfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lkfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

### hw/rtl/lkfs_front.sv
// Front end: accepts items, drops loads outside the image and queues the rest.
`default_nettype none
module lkfs_front import lkfs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_data_i,
  output logic          q_valid_o,
  input  wire logic     q_ready_i,
  output in_item_t      q_item_o
);

  localparam int PtrW = $clog2(Q_DEPTH);
  localparam int CntW = $clog2(Q_DEPTH + 1);

  in_item_t          fifo_q [Q_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              in_image;
  logic              push, pop;

  assign in_image = (int'(in_data_i.pixel_x) < IMG_W) && (int'(in_data_i.pixel_y) < IMG_H);
  assign in_ready_o = (cnt_q != CntW'(Q_DEPTH));
  // A query is always kept; a load outside the image is accepted and dropped.
  assign push = in_valid_i && in_ready_o && (in_data_i.kind == KIND_QUERY || in_image);
  assign q_valid_o = (cnt_q != '0);
  assign pop = q_valid_o && q_ready_i;
  assign q_item_o = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lkfs_div.sv
// Restoring divider, one quotient bit per cycle, with Q16.16 saturation.
`default_nettype none
module lkfs_div import lkfs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CntW = $clog2(DIVD_W + 1);
  localparam int RemW = NUM_W + 1;

  logic              busy_q, done_q, neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [RemW-1:0]   rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [NUM_W-1:0]  den_q;
  logic [FLOW_W-1:0] res_q;
  logic [RemW-1:0]   rem_sh;
  logic [RemW:0]     diff;
  logic              fits;
  logic [FLOW_W-1:0] sat;

  assign rem_sh = {rem_q[RemW-2:0], quo_q[DIVD_W-1]};
  assign diff = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits = !diff[RemW];

  always_comb begin
    if (neg_q) begin
      if ((|quo_q[DIVD_W-1:FLOW_W]) || (quo_q[FLOW_W-1] && (|quo_q[FLOW_W-2:0]))) begin
        sat = {1'b1, {(FLOW_W-1){1'b0}}};
      end else begin
        sat = -quo_q[FLOW_W-1:0];
      end
    end else begin
      if (|quo_q[DIVD_W-1:FLOW_W-1]) begin
        sat = {1'b0, {(FLOW_W-1){1'b1}}};
      end else begin
        sat = quo_q[FLOW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      res_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.neg;
        cnt_q  <= CntW'(DIVD_W);
        rem_q  <= '0;
        quo_q  <= {req_i.mag, {FRAC_W{1'b0}}};
        den_q  <= req_i.den;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          res_q  <= sat;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
          rem_q <= fits ? diff[RemW-1:0] : rem_sh;
          quo_q <= {quo_q[DIVD_W-2:0], fits};
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, quot: res_q};

endmodule
`default_nettype wire

### hw/rtl/lkfs_back.sv
// Back end: image stores, window walk, 2x2 solve and result register.
`default_nettype none
module lkfs_back import lkfs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      q_valid_i,
  output logic           q_ready_o,
  input  wire in_item_t  q_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_TAP, ST_SOLVE, ST_DIVX, ST_DIVY, ST_FIN} state_e;

  localparam logic [2:0] PH_C = 3'd0;
  localparam logic [2:0] PH_R = 3'd1;
  localparam logic [2:0] PH_L = 3'd2;
  localparam logic [2:0] PH_D = 3'd3;
  localparam logic [2:0] PH_U = 3'd4;
  localparam logic [2:0] PH_MUL = 3'd5;
  localparam logic [2:0] PH_ACC = 3'd6;

  localparam logic [2:0] S_DETA = 3'd0;
  localparam logic [2:0] S_DETB = 3'd1;
  localparam logic [2:0] S_DET = 3'd2;
  localparam logic [2:0] S_NXB = 3'd3;
  localparam logic [2:0] S_NX = 3'd4;
  localparam logic [2:0] S_NYB = 3'd5;
  localparam logic [2:0] S_NY = 3'd6;

  localparam logic signed [C_W-1:0] ONE_C = C_W'(1);
  localparam logic signed [C_W-1:0] R_POS = C_W'(WIN_R);
  localparam logic signed [C_W-1:0] R_NEG = C_W'(-WIN_R);

  state_e                    state_q;
  logic [2:0]                ph_q, step_q;
  logic signed [C_W-1:0]     px_q, py_q, wx_q, wy_q;
  logic [VAL_W-1:0]          c1_q, c2_q, rt_q, lf_q, dn_q;
  logic signed [PROD_W-1:0]  pxx_q, pxy_q, pyy_q, pbx_q, pby_q;
  logic signed [SUM_W-1:0]   gxx_q, gxy_q, gyy_q, bx_q, by_q;
  logic signed [MUL_W-1:0]   prod_q, t_q;
  logic signed [NUM_W-1:0]   det_q, numx_q, numy_q;
  logic signed [FLOW_W-1:0]  fx_q, fy_q;
  logic                      solved_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  logic signed [C_W-1:0]     tx, ty;
  logic [ADDR_W-1:0]         raddr, waddr;
  logic                      we;
  logic [VAL_W-1:0]          rd1, rd2;
  logic signed [VAL_W:0]     dx, dy, dt;
  logic signed [PROD_W-1:0]  gx_e, gy_e, dt_e;
  logic signed [SUM_W-1:0]   mul_a, mul_b;
  logic signed [MUL_W-1:0]   prod;
  logic signed [NUM_W-1:0]   div_num;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign q_ready_o = (state_q == ST_IDLE);
  assign we = q_valid_i && q_ready_o && (q_item_i.kind == KIND_LOAD);
  assign waddr = ADDR_W'(q_item_i.pixel_y) * ADDR_W'(IMG_W) + ADDR_W'(q_item_i.pixel_x);

  assign tx = px_q + wx_q;
  assign ty = py_q + wy_q;

  always_comb begin
    case (ph_q)
      PH_C:    raddr = pix_addr(tx, ty);
      PH_R:    raddr = pix_addr(tx + ONE_C, ty);
      PH_L:    raddr = pix_addr(tx - ONE_C, ty);
      PH_D:    raddr = pix_addr(tx, ty + ONE_C);
      default: raddr = pix_addr(tx, ty - ONE_C);
    endcase
  end

  lkfs_ram #(.Width(VAL_W), .Depth(IMG_W * IMG_H)) u_first (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (q_item_i.first_value),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  lkfs_ram #(.Width(VAL_W), .Depth(IMG_W * IMG_H)) u_second (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (q_item_i.second_value),
    .raddr_i (raddr),
    .rdata_o (rd2)
  );

  // Gradients are floor-halved differences; dropping the low bit is the arithmetic shift.
  assign dx = signed'({1'b0, rt_q}) - signed'({1'b0, lf_q});
  assign dy = signed'({1'b0, dn_q}) - signed'({1'b0, rd1});
  assign dt = signed'({1'b0, c1_q}) - signed'({1'b0, c2_q});
  assign gx_e = PROD_W'(signed'(dx[VAL_W:1]));
  assign gy_e = PROD_W'(signed'(dy[VAL_W:1]));
  assign dt_e = PROD_W'(dt);

  always_comb begin
    case (step_q)
      S_DETA:  begin mul_a = gxx_q; mul_b = gyy_q; end
      S_DETB:  begin mul_a = gxy_q; mul_b = gxy_q; end
      S_DET:   begin mul_a = gyy_q; mul_b = bx_q;  end
      S_NXB:   begin mul_a = gxy_q; mul_b = by_q;  end
      S_NX:    begin mul_a = gxx_q; mul_b = by_q;  end
      default: begin mul_a = gxy_q; mul_b = bx_q;  end
    endcase
  end
  assign prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  assign div_num = (state_q == ST_SOLVE) ? numx_q : numy_q;
  assign div_req.start = ((state_q == ST_SOLVE) && (step_q == S_NY) && (det_q > 1)) ||
                         ((state_q == ST_DIVX) && div_rsp.done);
  assign div_req.neg = div_num[NUM_W-1];
  assign div_req.mag = div_num[NUM_W-1] ? NUM_W'(-div_num) : NUM_W'(div_num);
  assign div_req.den = NUM_W'(det_q);

  lkfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_C;
      step_q      <= S_DETA;
      px_q        <= '0;
      py_q        <= '0;
      wx_q        <= '0;
      wy_q        <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      rt_q        <= '0;
      lf_q        <= '0;
      dn_q        <= '0;
      pxx_q       <= '0;
      pxy_q       <= '0;
      pyy_q       <= '0;
      pbx_q       <= '0;
      pby_q       <= '0;
      gxx_q       <= '0;
      gxy_q       <= '0;
      gyy_q       <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      prod_q      <= '0;
      t_q         <= '0;
      det_q       <= '0;
      numx_q      <= '0;
      numy_q      <= '0;
      fx_q        <= '0;
      fy_q        <= '0;
      solved_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i && q_item_i.kind == KIND_QUERY) begin
            state_q <= ST_TAP;
            ph_q    <= PH_C;
            px_q    <= C_W'(q_item_i.pixel_x);
            py_q    <= C_W'(q_item_i.pixel_y);
            wx_q    <= R_NEG;
            wy_q    <= R_NEG;
            gxx_q   <= '0;
            gxy_q   <= '0;
            gyy_q   <= '0;
            bx_q    <= '0;
            by_q    <= '0;
          end
        end
        ST_TAP: begin
          ph_q <= (ph_q == PH_ACC) ? PH_C : ph_q + 3'd1;
          case (ph_q)
            PH_R: begin
              c1_q <= rd1;
              c2_q <= rd2;
            end
            PH_L: rt_q <= rd1;
            PH_D: lf_q <= rd1;
            PH_U: dn_q <= rd1;
            PH_MUL: begin
              pxx_q <= gx_e * gx_e;
              pxy_q <= gx_e * gy_e;
              pyy_q <= gy_e * gy_e;
              pbx_q <= dt_e * gx_e;
              pby_q <= dt_e * gy_e;
            end
            PH_ACC: begin
              gxx_q <= gxx_q + SUM_W'(pxx_q);
              gxy_q <= gxy_q + SUM_W'(pxy_q);
              gyy_q <= gyy_q + SUM_W'(pyy_q);
              bx_q  <= bx_q + SUM_W'(pbx_q);
              by_q  <= by_q + SUM_W'(pby_q);
              if (wx_q == R_POS) begin
                wx_q <= R_NEG;
                if (wy_q == R_POS) begin
                  state_q <= ST_SOLVE;
                  step_q  <= S_DETA;
                end else begin
                  wy_q <= wy_q + ONE_C;
                end
              end else begin
                wx_q <= wx_q + ONE_C;
              end
            end
            default: begin
            end
          endcase
        end
        ST_SOLVE: begin
          prod_q <= prod;
          step_q <= (step_q == S_NY) ? S_DETA : step_q + 3'd1;
          case (step_q)
            S_DETB: t_q <= prod_q;
            S_DET:  det_q <= NUM_W'(t_q) - NUM_W'(prod_q);
            S_NXB:  t_q <= prod_q;
            S_NX:   numx_q <= NUM_W'(t_q) - NUM_W'(prod_q);
            S_NYB:  t_q <= prod_q;
            S_NY: begin
              numy_q <= NUM_W'(t_q) - NUM_W'(prod_q);
              if (det_q > 1) begin
                state_q <= ST_DIVX;
              end else begin
                fx_q     <= '0;
                fy_q     <= '0;
                solved_q <= 1'b0;
                state_q  <= ST_FIN;
              end
            end
            default: begin
            end
          endcase
        end
        ST_DIVX: begin
          if (div_rsp.done) begin
            fx_q    <= div_rsp.quot;
            state_q <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_rsp.done) begin
            fy_q     <= div_rsp.quot;
            solved_q <= 1'b1;
            state_q  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_q       <= '{flow_x: fx_q, flow_y: fy_q, solved: solved_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire
